// File: hdl/lpoe_pkg.sv
// Shared types, constants and step arithmetic for the lattice path orbit enumerator.
`timescale 1ns / 1ps
`default_nettype none

package lpoe_pkg;

    localparam int STEP_W   = 4;
    localparam int SLOTS    = 8;
    localparam int SLOT_W   = 3;
    localparam int WORD_W   = STEP_W * SLOTS;
    localparam int LEN_W    = 4;
    localparam int IDX_W    = 9;
    localparam int SIZE_W   = 9;
    localparam int SYM_W    = 4;
    localparam int PERM_W   = 5;
    localparam int SIGN_W   = 4;
    localparam int NUM_PERMS = 24;
    localparam int TDATA_W  = 48;

    localparam logic [LEN_W-1:0]  MAX_STEPS = LEN_W'(8);
    localparam logic [PERM_W-1:0] PERM_LAST = PERM_W'(NUM_PERMS - 1);
    localparam logic [SIGN_W-1:0] SIGN_LAST = '1;

    localparam logic OP_ENUM = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Axis permutations in lexicographic order; destination of axis k in bits 2k+1:2k
    localparam logic [7:0] PERM_TAB [NUM_PERMS] = '{
        {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
        {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
        {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
        {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
        {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
        {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
        {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
        {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
        {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
    };

    typedef struct packed {
        logic load;
        logic shift;
    } rb_ctrl_t;

    typedef struct packed {
        logic              match;
        logic [SYM_W-1:0]  sym;
        logic [WORD_W-1:0] cand;
    } rb_stat_t;

    function automatic logic [STEP_W-1:0] neg_step(input logic [STEP_W-1:0] s);
        return STEP_W'(~s + STEP_W'(1));
    endfunction

    function automatic logic step_ok(input logic [STEP_W-1:0] s);
        return (s >= STEP_W'(1) && s <= STEP_W'(4)) || s >= STEP_W'(12);
    endfunction

    function automatic logic path_ok(input logic [WORD_W-1:0] w, input logic [LEN_W-1:0] n);
        logic ok;
        ok = (n >= LEN_W'(1)) && (n <= MAX_STEPS);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i < int'(n) && !step_ok(w[i*STEP_W +: STEP_W]))
                ok = 1'b0;
        end
        return ok;
    endfunction

    // Zero the nibbles at and above the path length
    function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                    input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i < int'(n))
                r[i*STEP_W +: STEP_W] = w[i*STEP_W +: STEP_W];
        end
        return r;
    endfunction

    // Reverse the path and negate every step
    function automatic logic [WORD_W-1:0] rev_word(input logic [WORD_W-1:0] w,
                                                   input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] r;
        logic [SLOT_W-1:0] j;
        r = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            j = SLOT_W'(int'(n) - 1 - i);
            if (i < int'(n))
                r[i*STEP_W +: STEP_W] = neg_step(w[j*STEP_W +: STEP_W]);
        end
        return r;
    endfunction

    // Rotate an n-step path left by one step
    function automatic logic [WORD_W-1:0] rot1(input logic [WORD_W-1:0] w,
                                               input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i + 1 < int'(n))
                r[i*STEP_W +: STEP_W] = w[((i + 1) % SLOTS)*STEP_W +: STEP_W];
            else if (i + 1 == int'(n))
                r[i*STEP_W +: STEP_W] = w[STEP_W-1:0];
        end
        return r;
    endfunction

    // Map one valid step through an axis permutation and sign pattern
    function automatic logic [STEP_W-1:0] xform_step(input logic [STEP_W-1:0] s,
                                                     input logic [PERM_W-1:0] perm,
                                                     input logic [SIGN_W-1:0] signs);
        logic              neg;
        logic [STEP_W-1:0] mag;
        logic [1:0]        ax;
        logic [1:0]        dst;
        logic [STEP_W-1:0] v;
        logic              flip;
        neg  = s[STEP_W-1];
        mag  = neg ? neg_step(s) : s;
        ax   = 2'(mag - STEP_W'(1));
        dst  = PERM_TAB[perm][{ax, 1'b0} +: 2];
        v    = STEP_W'({2'b00, dst}) + STEP_W'(1);
        flip = neg ^ signs[2'd3 - ax];
        return flip ? neg_step(v) : v;
    endfunction

    function automatic logic [WORD_W-1:0] xform_word(input logic [WORD_W-1:0] w,
                                                     input logic [LEN_W-1:0] n,
                                                     input logic [PERM_W-1:0] perm,
                                                     input logic [SIGN_W-1:0] signs);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i < int'(n))
                r[i*STEP_W +: STEP_W] = xform_step(w[i*STEP_W +: STEP_W], perm, signs);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lpoe_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lpoe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/lpoe_rotbank.sv
// Rotation bank and shared compare unit for orbit membership tests.
`timescale 1ns / 1ps
`default_nettype none

module lpoe_rotbank import lpoe_pkg::*; (
    input  wire logic              clk,
    input  wire rb_ctrl_t          ctrl,
    input  wire logic [LEN_W-1:0]  len,
    input  wire logic [WORD_W-1:0] cand_fwd,
    input  wire logic [WORD_W-1:0] cand_rev,
    input  wire logic [WORD_W-1:0] rd_word,
    output rb_stat_t               stat
);

    logic [WORD_W-1:0] fwd_reg [SLOTS];
    logic [WORD_W-1:0] rev_reg [SLOTS];

    // Load slot zero, then shift the line while slot zero turns by one step
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            fwd_reg[0] <= cand_fwd;
            rev_reg[0] <= cand_rev;
        end
        else if (ctrl.shift)
        begin
            fwd_reg[0] <= rot1(fwd_reg[0], len);
            rev_reg[0] <= rot1(rev_reg[0], len);
            for (int j = 1; j < SLOTS; j++)
            begin
                fwd_reg[j] <= fwd_reg[j-1];
                rev_reg[j] <= rev_reg[j-1];
            end
        end
    end

    // Slot j holds rotation SLOTS-1-j; only rotations below the length count as symmetries
    always_comb
    begin
        logic             hit;
        logic [SYM_W-1:0] cnt;
        hit = 1'b0;
        cnt = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (fwd_reg[j] == rd_word || rev_reg[j] == rd_word)
                hit = 1'b1;
            if (fwd_reg[j] == rd_word && (SLOTS - 1 - j) < int'(len))
                cnt = cnt + SYM_W'(1);
        end
        stat.match = hit;
        stat.sym   = cnt;
        stat.cand  = fwd_reg[SLOTS-1];
    end

endmodule

`default_nettype wire

// File: hdl/lattice_path_orbit_enumerator.sv
// Top level of the lattice path orbit enumerator: sequencer, orbit store and handshakes.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// s_*      in         s_tvalid / s_tready    tuser: opcode; tdata: path_word, path_length,
//                                            entry_index
// m_*      out        m_tvalid / m_tready    tuser: entry_valid; tdata: orbit_size,
//                                            symmetry_count, entry_word
// cfg_*    in         cfg_valid / cfg_ready  cfg_data: group_mode (always ready)
//
// One word at a time; s_tready is high only when idle with no result word held.
// An enumerate stores the input path, then for each transform loads and shifts the rotation
// bank and scans the stored paths until one matches; if none does and the store has room,
// the transformed path is appended. A transform outside the three-axis group is skipped.
// The single read port of the orbit store scans one stored path a cycle.
// Reset clears control state and the orbit count at once; no clearing pass is run.

module lattice_path_orbit_enumerator import lpoe_pkg::*; #(
    parameter int ORBIT_DEPTH = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [31:0] path_word, [35:32] path_length,
                                               // [44:36] entry_index, zero above
    input  wire logic [0:0]         s_tuser,   // [0] opcode
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [8:0] orbit_size, [12:9] symmetry_count,
                                               // [44:13] entry_word, zero above
    output logic [0:0]              m_tuser,   // [0] entry_valid
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data   // group_mode
);

    localparam int CNT_W  = $clog2(ORBIT_DEPTH + 1);
    localparam int ADDR_W = $clog2(ORBIT_DEPTH);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int PAD_W  = TDATA_W - SIZE_W - SYM_W - WORD_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_RD_OUT, ST_START, ST_SEL, ST_LOAD,
        ST_SHIFT, ST_SCAN, ST_NEXT, ST_FIN
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;
    logic                 mode_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic                 pend_reg, pend_next;
    logic                 first_reg, first_next;
    logic [PERM_W-1:0]    perm_reg, perm_next;
    logic [SIGN_W-1:0]    sign_reg, sign_next;
    logic [SLOT_W-1:0]    sh_reg, sh_next;

    // Payload
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_W-1:0]    rev_reg, rev_next;
    logic [SYM_W-1:0]     sym_reg, sym_next;

    logic                 s_accept;
    logic                 issue;
    logic                 in_group;
    logic                 rd_hit;
    logic [WORD_W-1:0]    in_word;
    logic [LEN_W-1:0]     in_len;
    logic [IDX_W-1:0]     in_idx;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]    ram_wr_data;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]    ram_rd_data;

    rb_ctrl_t             rb_ctrl;
    rb_stat_t             rb_stat;

    assign in_word   = s_tdata[WORD_W-1:0];
    assign in_len    = s_tdata[WORD_W +: LEN_W];
    assign in_idx    = s_tdata[WORD_W + LEN_W +: IDX_W];

    assign s_tready  = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Keep issuing stored paths while any remain
    assign issue    = k_reg < count_reg;
    assign rd_hit   = CMP_W'(idx_reg) < CMP_W'(count_reg);
    // The three-axis group keeps axis four in place and never flips it
    assign in_group = !mode_reg || (PERM_TAB[perm_reg][7:6] == 2'd3 && !sign_reg[0]);

    lpoe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ORBIT_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lpoe_rotbank u_rotbank (
        .clk      (clk),
        .ctrl     (rb_ctrl),
        .len      (len_reg),
        .cand_fwd (xform_word(word_reg, len_reg, perm_reg, sign_reg)),
        .cand_rev (xform_word(rev_reg, len_reg, perm_reg, sign_reg)),
        .rd_word  (ram_rd_data),
        .stat     (rb_stat)
    );

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        pend_next     = 1'b0;
        first_next    = first_reg;
        perm_next     = perm_reg;
        sign_next     = sign_reg;
        sh_next       = sh_reg;
        word_next     = word_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        rev_next      = rev_reg;
        sym_next      = sym_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = count_reg[ADDR_W-1:0];
        ram_wr_data   = rb_stat.cand;
        ram_rd_addr   = k_reg[ADDR_W-1:0];
        rb_ctrl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    word_next = in_word;
                    len_next  = in_len;
                    idx_next  = in_idx;
                    if (s_tuser[0] == OP_READ)
                        state_next = ST_RD;
                    else if (!path_ok(in_word, in_len))
                    begin
                        // Drop the orbit and answer at once
                        count_next    = '0;
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tuser_next  = 1'b0;
                    end
                    else
                        state_next = ST_START;
                end
            end

            ST_RD:
            begin
                ram_rd_addr = ADDR_W'(idx_reg);
                state_next  = ST_RD_OUT;
            end

            ST_RD_OUT:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {PAD_W'(0), rd_hit ? ram_rd_data : WORD_W'(0),
                                 SYM_W'(0), SIZE_W'(count_reg)};
                m_tuser_next  = rd_hit;
                state_next    = ST_IDLE;
            end

            ST_START:
            begin
                // Store the input path first
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = mask_word(word_reg, len_reg);
                count_next  = CNT_W'(1);
                rev_next    = rev_word(word_reg, len_reg);
                perm_next   = '0;
                sign_next   = '0;
                first_next  = 1'b1;
                state_next  = ST_SEL;
            end

            ST_SEL:
                state_next = in_group ? ST_LOAD : ST_NEXT;

            ST_LOAD:
            begin
                rb_ctrl.load = 1'b1;
                sh_next      = '0;
                state_next   = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                rb_ctrl.shift = 1'b1;
                sh_next       = sh_reg + SLOT_W'(1);
                if (sh_reg == SLOT_W'(SLOTS - 2))
                begin
                    k_next     = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (issue)
                    k_next = k_reg + CNT_W'(1);
                pend_next = issue;
                if (pend_reg && rb_stat.match)
                begin
                    // The identity transform meets the input path at entry zero
                    if (first_reg)
                        sym_next = rb_stat.sym;
                    first_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_NEXT;
                end
                else if (!issue && !pend_reg)
                begin
                    // New path: append unless the store is full
                    if (count_reg < CNT_W'(ORBIT_DEPTH))
                    begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    first_next = 1'b0;
                    state_next = ST_NEXT;
                end
            end

            ST_NEXT:
            begin
                if (perm_reg == PERM_LAST && sign_reg == SIGN_LAST)
                    state_next = ST_FIN;
                else
                begin
                    sign_next = sign_reg + SIGN_W'(1);
                    if (sign_reg == SIGN_LAST)
                        perm_next = perm_reg + PERM_W'(1);
                    state_next = ST_SEL;
                end
            end

            ST_FIN:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {PAD_W'(0), WORD_W'(0), sym_reg, SIZE_W'(count_reg)};
                m_tuser_next  = 1'b0;
                state_next    = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
            mode_reg     <= 1'b0;
            count_reg    <= '0;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            first_reg    <= 1'b0;
            perm_reg     <= '0;
            sign_reg     <= '0;
            sh_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            count_reg    <= count_next;
            k_reg        <= k_next;
            pend_reg     <= pend_next;
            first_reg    <= first_next;
            perm_reg     <= perm_next;
            sign_reg     <= sign_next;
            sh_reg       <= sh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        rev_reg  <= rev_next;
        sym_reg  <= sym_next;
    end

`ifndef SYNTHESIS
    a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !s_tready)
        else $error("input accepted while a result word is pending");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ORBIT_DEPTH))
        else $error("orbit count beyond store depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
        else $error("scan started on an empty orbit store");

    a_write_only_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && state_reg == ST_SCAN) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("store written without advancing the orbit count");
`endif

endmodule

`default_nettype wire
